/* rtl/core/sjpq_pkg.sv */
package sjpq_pkg;

    // Request kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] job_tag;
        logic [15:0] page_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [15:0] out_pages;
        logic        now_empty;
    } rsp_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] pages;
    } entry_t;

    // Read address source for the store
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_PREV,
        RD_PREV2
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       shift;
        logic       place;
        logic       pop;
        logic       res_set;
        logic [1:0] res_code;
        logic       res_take;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic at_front;
        logic at_second;
        logic rd_gt;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/sjpq_ram.sv */
module sjpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/sjpq_datapath.sv */
module sjpq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sjpq_pkg::req_t   req,
    input  sjpq_pkg::cmd_t   cmd,
    output sjpq_pkg::stat_t  stat,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output sjpq_pkg::rsp_t   rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    sjpq_pkg::req_t   job_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [1:0]       res_status_reg;
    logic [15:0]      res_tag_reg;
    logic [15:0]      res_pages_reg;
    sjpq_pkg::rsp_t   rsp_reg;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [SUM_W-1:0]       tail_sum;
    logic [PTR_W-1:0]       tail_ptr;
    logic [PTR_W-1:0]       prev_ptr;
    logic [PTR_W-1:0]       prev2_ptr;
    logic [PTR_W-1:0]       head_inc;
    logic [PTR_W-1:0]       raddr;
    logic                   we;
    sjpq_pkg::entry_t       wentry;
    sjpq_pkg::entry_t       rentry;
    logic [$bits(sjpq_pkg::entry_t)-1:0] rdata;

    // Slot just past the last stored job
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_ptr  = tail_sum[PTR_W-1:0];
        prev_ptr  = (wptr_reg == '0) ? LAST : wptr_reg - PTR_W'(1);
        prev2_ptr = (prev_ptr == '0) ? LAST : prev_ptr - PTR_W'(1);
        head_inc  = (head_reg == LAST) ? '0 : head_reg + PTR_W'(1);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            sjpq_pkg::RD_PREV:  raddr = prev_ptr;
            sjpq_pkg::RD_PREV2: raddr = prev2_ptr;
            default:            raddr = head_reg;
        endcase
    end

    assign rentry = sjpq_pkg::entry_t'(rdata);
    assign we     = cmd.shift | cmd.place;
    assign wentry = cmd.shift ? rentry
                              : sjpq_pkg::entry_t'({job_reg.job_tag, job_reg.page_count});

    sjpq_ram #(
        .WIDTH ($bits(sjpq_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wptr_reg),
        .wdata (wentry),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        wptr_next  = wptr_reg;
        if (cmd.load)
        begin
            pos_next  = count_reg;
            wptr_next = tail_ptr;
        end
        if (cmd.shift)
        begin
            pos_next  = pos_reg - CNT_W'(1);
            wptr_next = prev_ptr;
        end
        if (cmd.place)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
        end
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            wptr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            wptr_reg      <= wptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            job_reg <= req;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_tag_reg    <= cmd.res_take ? rentry.tag : 16'd0;
            res_pages_reg  <= cmd.res_take ? rentry.pages : 16'd0;
        end
        if (cmd.emit)
        begin
            rsp_reg.status    <= res_status_reg;
            rsp_reg.out_tag   <= res_tag_reg;
            rsp_reg.out_pages <= res_pages_reg;
            rsp_reg.now_empty <= (count_reg == '0);
        end
    end

    assign stat.kind      = job_reg.kind;
    assign stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.at_front  = (pos_reg == '0);
    assign stat.at_second = (pos_reg == CNT_W'(1));
    assign stat.rd_gt     = (rentry.pages > job_reg.page_count);
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/sjpq_ctrl.sv */
module sjpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sjpq_pkg::stat_t stat,
    output sjpq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_PLACE,
        S_DEQ,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   req_stall_reg, req_stall_next;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = sjpq_pkg::RD_HEAD;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.kind == sjpq_pkg::KIND_ENQ)
                begin
                    if (stat.full)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sjpq_pkg::ST_FULL;
                        state_next   = S_EMIT;
                    end
                    else if (stat.at_front)
                    begin
                        cmd.place    = 1'b1;
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sjpq_pkg::ST_ENQUEUED;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sjpq_pkg::RD_PREV;
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    if (stat.empty)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sjpq_pkg::ST_EMPTY;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sjpq_pkg::RD_HEAD;
                        state_next = S_DEQ;
                    end
                end
            end
            S_WALK:
            begin
                // Move the larger job up one slot, or drop the new one in here
                if (stat.rd_gt)
                begin
                    cmd.shift = 1'b1;
                    if (stat.at_second)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sjpq_pkg::RD_PREV2;
                    end
                end
                else
                begin
                    cmd.place    = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sjpq_pkg::ST_ENQUEUED;
                    state_next   = S_EMIT;
                end
            end
            S_PLACE:
            begin
                cmd.place    = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = sjpq_pkg::ST_ENQUEUED;
                state_next   = S_EMIT;
            end
            S_DEQ:
            begin
                cmd.pop      = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = sjpq_pkg::ST_DEQUEUED;
                cmd.res_take = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        req_stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_stall_reg <= req_stall_next;
        end
    end

    assign req_stall = req_stall_reg;

endmodule

/* rtl/core/shortest_job_priority_queue.sv */
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req : enqueue or dequeue, tag, page count
// response  out        rsp_valid/rsp_stall   rsp : status, tag, pages, now_empty
//
// One request at a time. A dequeue reads and pops the head; an enqueue walks back
// from the tail past every stored job with more pages than the new one, shifting
// each up one slot through the single write port of the store, which moves one job
// per cycle; a drop when full or an enqueue into an empty store skips the walk. The
// next request is taken in the cycle after the response is loaded. Reset empties
// the queue at once, the store itself is not cleared; a waiting response holds in
// its register while the next request is taken.
module shortest_job_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sjpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sjpq_pkg::rsp_t rsp
);

    // Command and status between the controller and the datapath
    sjpq_pkg::cmd_t  cmd;
    sjpq_pkg::stat_t stat;

    // Sequence each request: accept, decide, walk the sorted store or pop its head, emit
    sjpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the sorted store as a ring: head is the smallest job, insertion
    // walks back from the tail and shifts larger jobs up one slot per cycle
    sjpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A shift and a placement never share the single write port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift && cmd.place))
        else $error("shift and place in the same cycle");

    // Never place a job into a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !stat.full)
        else $error("place into full store");

    // Never pop from an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop from empty store");

    // A response only leaves when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("response overwrites a waiting one");

    // An emitted response shows up in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp_valid)
        else $error("emitted response not valid");

endmodule
